/* rtl/core/ssq_pkg.sv */
// ----------------------------------------------------------------------------
// Step sequencer package
// Shared constants, codes and types of the step sequencer with a wrap range.
// ----------------------------------------------------------------------------
package ssq_pkg;

	// Number of entries in the step memory.
	localparam int unsigned MAX_STEPS = 64;
	localparam int unsigned POS_W     = $clog2(MAX_STEPS);
	localparam int unsigned LEN_W     = POS_W + 1;

	// Field widths of the request and result words.
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned VAL_W   = 16;

	// Configuration register widths.
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned BND_W   = 6;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned CFG_AW  = 3;
	localparam int unsigned CFG_DW  = 8;

	// Signed offset handed to the wrap unit and its magnitude.
	localparam int unsigned OFS_W   = STEP_W + 2;
	localparam int unsigned MAG_W   = OFS_W - 1;
	localparam int unsigned BCNT_W  = $clog2(MAG_W + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_TRIGGER     = 3'd0,
		REQ_RESET_START = 3'd1,
		REQ_RESET_STEP  = 3'd2,
		REQ_WRITE       = 3'd3,
		REQ_READ        = 3'd4,
		REQ_PEEK        = 3'd5
	} req_code_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_ACTIVE_COUNT = 3'd0,
		CFG_RANGE_FIRST  = 3'd1,
		CFG_RANGE_LAST   = 3'd2,
		CFG_STEP_SIZE    = 3'd3,
		CFG_RUN_BACKWARD = 3'd4
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_WRAP,
		ST_READ,
		ST_RESP
	} state_t;

	// Start request to the serial wrap unit.
	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [LEN_W-1:0] len;
	} wrap_req_t;

	// Answer of the serial wrap unit.
	typedef struct packed {
		logic             done;
		logic [POS_W-1:0] rem;
	} wrap_rsp_t;

endpackage

/* rtl/core/ssq_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request word into the sequencer.
// ----------------------------------------------------------------------------
interface ssq_req_if;
	logic                       valid;
	logic                       ready;
	logic [ssq_pkg::REQ_W-1:0]  req_type;
	logic [ssq_pkg::IDX_W-1:0]  step_index;
	logic signed [ssq_pkg::VAL_W-1:0] step_value;

	modport source (output valid, req_type, step_index, step_value, input ready);
	modport sink   (input valid, req_type, step_index, step_value, output ready);
endinterface

/* rtl/core/ssq_rsp_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result word out of the sequencer.
// ----------------------------------------------------------------------------
interface ssq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [ssq_pkg::VAL_W-1:0] out_value;
	logic [ssq_pkg::POS_W-1:0]        current_step;
	logic                             at_range_start;
	logic                             at_range_end;

	modport source (output valid, out_value, current_step, at_range_start, at_range_end,
		input ready);
	modport sink   (input valid, out_value, current_step, at_range_start, at_range_end,
		output ready);
endinterface

/* rtl/core/ssq_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface ssq_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ssq_pkg::CFG_AW-1:0] index;
	logic [ssq_pkg::CFG_DW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/step_sequencer_with_wrap_range.sv */
// ----------------------------------------------------------------------------
// Step sequencer with wrap range
// Step value memory with a current step that moves inside a clamped range.
// ----------------------------------------------------------------------------
// The block holds 64 signed 16-bit step values, a current step and a hold
// flag, and answers every request word with exactly one result word. Requests
// are handled one at a time. A reset to the start of the range, a write, a
// read, a peek or a trigger right after a reset (which only clears the hold
// flag) is taken in the idle state and passes through the clamp, read and
// response states. A trigger that is not held and a reset to a given step
// also pass through the wrap state between clamp and read, since the wrap
// into the range is a signed modulo by the range length that a serial unit
// works out one bit per cycle over the nine magnitude bits of the offset,
// then raises its done flag. The result sits in an output register, so the next
// request word is taken while the previous result still waits; a new result
// only waits for that register to empty. Configuration is written over its
// own channel, which is always ready; it must be written only while no
// request is in flight. Entries of the step memory must be written before
// they are read.
// ----------------------------------------------------------------------------
module step_sequencer_with_wrap_range (
	input  logic         clk,
	input  logic         arst_n,
	ssq_req_if.sink      req,
	ssq_rsp_if.source    rsp,
	ssq_cfg_if.sink      cfg
);

	// Configuration registers.
	logic [ssq_pkg::CNT_W-1:0]  active_count_q;
	logic [ssq_pkg::BND_W-1:0]  range_first_q;
	logic [ssq_pkg::BND_W-1:0]  range_last_q;
	logic [ssq_pkg::STEP_W-1:0] step_size_q;
	logic                       run_backward_q;

	// Sequencer state.
	ssq_pkg::state_t            state_q;
	ssq_pkg::state_t            state_d;
	logic [ssq_pkg::POS_W-1:0]  pos_q;
	logic                       hold_q;

	// Captured request word.
	logic [ssq_pkg::REQ_W-1:0]  req_type_q;
	logic [ssq_pkg::IDX_W-1:0]  step_index_q;
	logic [ssq_pkg::VAL_W-1:0]  step_value_q;

	// Step memory and its registered read port.
	logic [ssq_pkg::VAL_W-1:0]  mem [ssq_pkg::MAX_STEPS];
	logic [ssq_pkg::VAL_W-1:0]  rd_data_q;

	// Output register.
	logic                       rsp_valid_q;
	logic [ssq_pkg::VAL_W-1:0]  out_value_q;
	logic [ssq_pkg::POS_W-1:0]  current_step_q;
	logic                       at_start_q;
	logic                       at_end_q;

	// Derived range.
	logic [ssq_pkg::CNT_W-1:0]  n_eff;
	logic [ssq_pkg::POS_W-1:0]  top;
	logic [ssq_pkg::POS_W-1:0]  bnd_a;
	logic [ssq_pkg::POS_W-1:0]  bnd_b;
	logic [ssq_pkg::POS_W-1:0]  lo;
	logic [ssq_pkg::POS_W-1:0]  hi;
	logic [ssq_pkg::LEN_W-1:0]  len;
	logic [ssq_pkg::POS_W-1:0]  pos_clamped;
	logic [ssq_pkg::POS_W-1:0]  mem_idx;
	logic [ssq_pkg::POS_W-1:0]  rd_addr;

	// Wrap offset.
	logic signed [ssq_pkg::OFS_W-1:0] rel;
	logic signed [ssq_pkg::OFS_W-1:0] step_ofs;
	logic signed [ssq_pkg::OFS_W-1:0] ofs;
	logic signed [ssq_pkg::OFS_W-1:0] ofs_abs;

	// Decoded control.
	logic                       is_trigger;
	logic                       is_reset_start;
	logic                       is_reset_step;
	logic                       is_write;
	logic                       is_read;
	logic                       needs_wrap;
	logic                       out_free;

	// Control outputs of the state machine.
	logic                       req_ready;
	logic                       clamp_en;
	logic                       wrap_start;
	logic                       rd_en;
	logic                       rsp_load;

	ssq_pkg::wrap_req_t         wreq;
	ssq_pkg::wrap_rsp_t         wrsp;

	// ------------------------------------------------------------------------
	// Configuration port. It never stalls; an index beyond the list is dropped.
	// ------------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= ssq_pkg::CNT_W'(64);
			range_first_q  <= '0;
			range_last_q   <= ssq_pkg::BND_W'(63);
			step_size_q    <= ssq_pkg::STEP_W'(1);
			run_backward_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				ssq_pkg::CFG_ACTIVE_COUNT: active_count_q <= cfg.data[ssq_pkg::CNT_W-1:0];
				ssq_pkg::CFG_RANGE_FIRST:  range_first_q  <= cfg.data[ssq_pkg::BND_W-1:0];
				ssq_pkg::CFG_RANGE_LAST:   range_last_q   <= cfg.data[ssq_pkg::BND_W-1:0];
				ssq_pkg::CFG_STEP_SIZE:    step_size_q    <= cfg.data[ssq_pkg::STEP_W-1:0];
				ssq_pkg::CFG_RUN_BACKWARD: run_backward_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Range. The active count is held to 1..MAX_STEPS, each bound is clamped to
	// the last active step and the two bounds are put in order.
	// ------------------------------------------------------------------------
	always_comb begin
		if (active_count_q == '0) begin
			n_eff = ssq_pkg::CNT_W'(1);
		end else if (active_count_q > ssq_pkg::CNT_W'(ssq_pkg::MAX_STEPS)) begin
			n_eff = ssq_pkg::CNT_W'(ssq_pkg::MAX_STEPS);
		end else begin
			n_eff = active_count_q;
		end
	end

	assign top   = ssq_pkg::POS_W'(n_eff - 1'b1);
	assign bnd_a = (range_first_q > top) ? top : range_first_q;
	assign bnd_b = (range_last_q > top) ? top : range_last_q;
	assign lo    = (bnd_a < bnd_b) ? bnd_a : bnd_b;
	assign hi    = (bnd_a < bnd_b) ? bnd_b : bnd_a;
	assign len   = {1'b0, hi} - {1'b0, lo} + 1'b1;

	// The stored step is first pulled into the range.
	always_comb begin
		if (pos_q > hi) begin
			pos_clamped = hi;
		end else if (pos_q < lo) begin
			pos_clamped = lo;
		end else begin
			pos_clamped = pos_q;
		end
	end

	// Read and write index, clamped to the last active step.
	assign mem_idx = (step_index_q > ssq_pkg::IDX_W'(top)) ? top
		: step_index_q[ssq_pkg::POS_W-1:0];

	// ------------------------------------------------------------------------
	// Request decode and the offset that gets wrapped. A trigger moves by the
	// step size from the clamped step; a reset to a step wraps the given index.
	// Both offsets are taken relative to the range start.
	// ------------------------------------------------------------------------
	assign is_trigger     = (req_type_q == ssq_pkg::REQ_TRIGGER);
	assign is_reset_start = (req_type_q == ssq_pkg::REQ_RESET_START);
	assign is_reset_step  = (req_type_q == ssq_pkg::REQ_RESET_STEP);
	assign is_write       = (req_type_q == ssq_pkg::REQ_WRITE);
	assign is_read        = (req_type_q == ssq_pkg::REQ_READ);
	assign needs_wrap     = (is_trigger && !hold_q) || is_reset_step;

	assign rel      = $signed({{(ssq_pkg::OFS_W-ssq_pkg::POS_W){1'b0}}, pos_clamped})
		- $signed({{(ssq_pkg::OFS_W-ssq_pkg::POS_W){1'b0}}, lo});
	assign step_ofs = $signed({{(ssq_pkg::OFS_W-ssq_pkg::STEP_W){1'b0}}, step_size_q});

	always_comb begin
		if (is_reset_step) begin
			ofs = $signed({{(ssq_pkg::OFS_W-ssq_pkg::IDX_W){1'b0}}, step_index_q})
				- $signed({{(ssq_pkg::OFS_W-ssq_pkg::POS_W){1'b0}}, lo});
		end else if (run_backward_q) begin
			ofs = rel - step_ofs;
		end else begin
			ofs = rel + step_ofs;
		end
	end

	assign ofs_abs = ofs[ssq_pkg::OFS_W-1] ? -ofs : ofs;

	assign wreq.start = wrap_start;
	assign wreq.neg   = ofs[ssq_pkg::OFS_W-1];
	assign wreq.mag   = ofs_abs[ssq_pkg::MAG_W-1:0];
	assign wreq.len   = len;

	ssq_wrap u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.wreq   (wreq),
		.wrsp   (wrsp)
	);

	// ------------------------------------------------------------------------
	// Sequencer: capture, clamp and decide, optional serial wrap, memory read,
	// then hand the result to the output register once it is free.
	// ------------------------------------------------------------------------
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssq_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = ssq_pkg::ST_CLAMP;
				end
			end
			ssq_pkg::ST_CLAMP: begin
				state_d = needs_wrap ? ssq_pkg::ST_WRAP : ssq_pkg::ST_READ;
			end
			ssq_pkg::ST_WRAP: begin
				if (wrsp.done) begin
					state_d = ssq_pkg::ST_READ;
				end
			end
			ssq_pkg::ST_READ: begin
				state_d = ssq_pkg::ST_RESP;
			end
			ssq_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = ssq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ssq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		clamp_en   = 1'b0;
		wrap_start = 1'b0;
		rd_en      = 1'b0;
		rsp_load   = 1'b0;
		case (state_q)
			ssq_pkg::ST_IDLE:  req_ready = 1'b1;
			ssq_pkg::ST_CLAMP: begin
				clamp_en   = 1'b1;
				wrap_start = needs_wrap;
			end
			ssq_pkg::ST_READ:  rd_en = 1'b1;
			ssq_pkg::ST_RESP:  rsp_load = out_free;
			default: ;
		endcase
	end

	assign req.ready = req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssq_pkg::ST_IDLE;
			pos_q   <= '0;
			hold_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clamp_en) begin
				// A trigger that follows a reset only releases the hold.
				if (is_trigger && hold_q) begin
					hold_q <= 1'b0;
				end
				if (is_reset_start) begin
					pos_q  <= lo;
					hold_q <= 1'b1;
				end else begin
					pos_q <= pos_clamped;
				end
			end else if ((state_q == ssq_pkg::ST_WRAP) && wrsp.done) begin
				pos_q <= lo + wrsp.rem;
				if (is_reset_step) begin
					hold_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			req_type_q   <= req.req_type;
			step_index_q <= req.step_index;
			step_value_q <= req.step_value;
		end
	end

	// ------------------------------------------------------------------------
	// Step memory: one write port used while clamping, one registered read.
	// ------------------------------------------------------------------------
	assign rd_addr = is_read ? mem_idx : pos_q;

	always_ff @(posedge clk) begin
		if (clamp_en && is_write) begin
			mem[mem_idx] <= step_value_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// ------------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_value_q    <= rd_data_q;
			current_step_q <= pos_q;
			at_start_q     <= (pos_q == lo);
			at_end_q       <= (pos_q == hi);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.out_value      = $signed(out_value_q);
	assign rsp.current_step   = current_step_q;
	assign rsp.at_range_start = at_start_q;
	assign rsp.at_range_end   = at_end_q;

endmodule

/* rtl/core/ssq_wrap.sv */
// ----------------------------------------------------------------------------
// Serial wrap unit
// Signed modulo of an offset by the range length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssq_wrap (
	input  logic                clk,
	input  logic                arst_n,
	input  ssq_pkg::wrap_req_t  wreq,
	output ssq_pkg::wrap_rsp_t  wrsp
);

	logic [ssq_pkg::MAG_W-1:0]  dvd_q;
	logic [ssq_pkg::POS_W-1:0]  rem_q;
	logic [ssq_pkg::LEN_W-1:0]  len_q;
	logic                       neg_q;
	logic [ssq_pkg::BCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [ssq_pkg::LEN_W-1:0]  trial;
	logic [ssq_pkg::LEN_W-1:0]  trial_sub;
	logic [ssq_pkg::LEN_W-1:0]  fixed;

	// Restoring step: bring in the next dividend bit, subtract if it fits.
	assign trial     = {rem_q, dvd_q[ssq_pkg::MAG_W-1]};
	assign trial_sub = trial - len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (wreq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ssq_pkg::BCNT_W'(ssq_pkg::MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ssq_pkg::BCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wreq.start) begin
			dvd_q <= wreq.mag;
			rem_q <= '0;
			len_q <= wreq.len;
			neg_q <= wreq.neg;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ssq_pkg::MAG_W-2:0], 1'b0};
			if (trial >= len_q) begin
				rem_q <= trial_sub[ssq_pkg::POS_W-1:0];
			end else begin
				rem_q <= trial[ssq_pkg::POS_W-1:0];
			end
		end
	end

	// A negative offset with a nonzero remainder folds back from the top.
	assign fixed = (neg_q && (rem_q != '0)) ? (len_q - {1'b0, rem_q}) : {1'b0, rem_q};

	assign wrsp.done = done_q;
	assign wrsp.rem  = fixed[ssq_pkg::POS_W-1:0];

endmodule

/* tb/sv/step_sequencer_with_wrap_range_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step sequencer with wrap range: testbench
// Drives request words through the valid/ready request channel and writes the
// configuration registers between phases. A behavioral model inside the bench
// predicts each result word, and a sink process compares the result words
// field by field, in order, while both sides stall at random.
// ----------------------------------------------------------------------------
module step_sequencer_with_wrap_range_test;

	// Request codes with no meaning of their own; the block treats them as a peek.
	localparam logic [ssq_pkg::REQ_W-1:0] REQ_SPARE_LOW  = 3'd6;
	localparam logic [ssq_pkg::REQ_W-1:0] REQ_SPARE_HIGH = 3'd7;

	// Longest path through the block is a trigger or a reset to a step that wraps;
	// this many quiet cycles cover it with room to spare.
	localparam int QUIET_CYCLES   = 16;
	// Cycles without any handshake after which the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Length of the deliberate stall of the result side.
	localparam int LONG_HOLD      = 200;

	typedef struct {
		logic signed [ssq_pkg::VAL_W-1:0] value;
		logic [ssq_pkg::POS_W-1:0]        step;
		logic                             at_start;
		logic                             at_end;
	} step_result_t;

	logic clk;
	logic arst_n;

	ssq_req_if req_bus();
	ssq_rsp_if rsp_bus();
	ssq_cfg_if cfg_bus();

	step_sequencer_with_wrap_range uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// Shadow copy of the configuration registers, starting at their reset values.
	logic [ssq_pkg::CNT_W-1:0]  cfg_count    = 7'd64;
	logic [ssq_pkg::BND_W-1:0]  cfg_first    = 6'd0;
	logic [ssq_pkg::BND_W-1:0]  cfg_last     = 6'd63;
	logic [ssq_pkg::STEP_W-1:0] cfg_step     = 8'd1;
	logic                       cfg_backward = 1'b0;

	// Shadow copy of the sequencer state.
	logic signed [ssq_pkg::VAL_W-1:0] step_mem [ssq_pkg::MAX_STEPS];
	int                               position = 0;
	logic                             hold_flag = 1'b0;

	// Result words predicted for accepted requests, oldest first.
	step_result_t pending_results[$];

	int mismatch_count = 0;
	int src_idle_pct   = 0;
	int sink_idle_pct  = 0;
	int rx_hold_cycles = 0;
	int quiet_cycles   = 0;

	// The clock runs at a 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Signed modulo of the offset from lo by the range length, never negative,
	// so a step that leaves the range on either side comes back in at the
	// other end.
	function automatic int wrapped(int x, int lo, int hi);
		int len;
		int rem;
		len = hi - lo + 1;
		rem = (x - lo) % len;
		if (rem < 0)
			rem += len;
		return lo + rem;
	endfunction

	// Works out the result word of one request and advances the shadow state.
	function automatic step_result_t predicted_result(logic [ssq_pkg::REQ_W-1:0] code,
		logic [ssq_pkg::IDX_W-1:0] idx, logic signed [ssq_pkg::VAL_W-1:0] val);
		int n;
		int first_b;
		int last_b;
		int lo;
		int hi;
		int idx_i;
		int mem_at;
		int delta;
		step_result_t r;
		// The count is held to 1..MAX_STEPS, both bounds to the last active step,
		// and the bounds are then put in order.
		n = cfg_count;
		if (n < 1)
			n = 1;
		if (n > ssq_pkg::MAX_STEPS)
			n = ssq_pkg::MAX_STEPS;
		first_b = cfg_first;
		last_b  = cfg_last;
		if (first_b > n - 1)
			first_b = n - 1;
		if (last_b > n - 1)
			last_b = n - 1;
		lo = (first_b < last_b) ? first_b : last_b;
		hi = (first_b < last_b) ? last_b : first_b;
		idx_i  = idx;
		mem_at = (idx_i > n - 1) ? n - 1 : idx_i;
		// A range change since the last word may have left the step outside.
		if (position > hi)
			position = hi;
		else if (position < lo)
			position = lo;
		case (code)
			ssq_pkg::REQ_TRIGGER: begin
				if (hold_flag) begin
					hold_flag = 1'b0;
				end else begin
					delta = cfg_step;
					if (cfg_backward)
						delta = -delta;
					position = wrapped(position + delta, lo, hi);
				end
			end
			ssq_pkg::REQ_RESET_START: begin
				position  = lo;
				hold_flag = 1'b1;
			end
			ssq_pkg::REQ_RESET_STEP: begin
				position  = wrapped(idx_i, lo, hi);
				hold_flag = 1'b1;
			end
			ssq_pkg::REQ_WRITE: begin
				step_mem[mem_at] = val;
			end
			default: begin
			end
		endcase
		r.value    = (code == ssq_pkg::REQ_READ) ? step_mem[mem_at] : step_mem[position];
		r.step     = position[ssq_pkg::POS_W-1:0];
		r.at_start = (position == lo);
		r.at_end   = (position == hi);
		return r;
	endfunction

	// Offers one request word, with an optional gap before it, and records the
	// predicted result once the block takes it. Called at a falling edge, and
	// returns at the falling edge after acceptance with valid still high.
	task automatic send_word(input logic [ssq_pkg::REQ_W-1:0] code,
		input logic [ssq_pkg::IDX_W-1:0] idx, input logic signed [ssq_pkg::VAL_W-1:0] val);
		if ($urandom_range(99) < src_idle_pct) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.req_type   <= code;
		req_bus.step_index <= idx;
		req_bus.step_value <= val;
		do
			@(posedge clk);
		while (!req_bus.ready);
		pending_results.push_back(predicted_result(code, idx, val));
		@(negedge clk);
	endtask

	// Stops offering words, waits for every predicted result, then lets the
	// block settle so that nothing is in flight.
	task automatic drain();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// One register write word. Valid is left high so that writes run back to
	// back; set_config lowers it after the last one.
	task automatic write_reg(input ssq_pkg::cfg_index_t index,
		input logic [ssq_pkg::CFG_DW-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data  <= data;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		case (index)
			ssq_pkg::CFG_ACTIVE_COUNT: cfg_count    = data[ssq_pkg::CNT_W-1:0];
			ssq_pkg::CFG_RANGE_FIRST:  cfg_first    = data[ssq_pkg::BND_W-1:0];
			ssq_pkg::CFG_RANGE_LAST:   cfg_last     = data[ssq_pkg::BND_W-1:0];
			ssq_pkg::CFG_STEP_SIZE:    cfg_step     = data[ssq_pkg::STEP_W-1:0];
			ssq_pkg::CFG_RUN_BACKWARD: cfg_backward = data[0];
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// Rewrites all registers, only once the block is idle.
	task automatic set_config(input int count, input int first_b, input int last_b,
		input int step, input bit backward);
		drain();
		write_reg(ssq_pkg::CFG_ACTIVE_COUNT, ssq_pkg::CFG_DW'(count));
		write_reg(ssq_pkg::CFG_RANGE_FIRST, ssq_pkg::CFG_DW'(first_b));
		write_reg(ssq_pkg::CFG_RANGE_LAST, ssq_pkg::CFG_DW'(last_b));
		write_reg(ssq_pkg::CFG_STEP_SIZE, ssq_pkg::CFG_DW'(step));
		write_reg(ssq_pkg::CFG_RUN_BACKWARD, ssq_pkg::CFG_DW'(backward));
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Every step value is written before anything reads it. Step zero goes first
	// since every result word shows the value at the current step, which is zero
	// after reset. This also checks the reset values of the registers.
	task automatic test_preload();
		send_word(ssq_pkg::REQ_WRITE, 8'd0, 16'sh7fff);
		send_word(ssq_pkg::REQ_WRITE, 8'd1, -16'sd32768);
		for (int i = 2; i < ssq_pkg::MAX_STEPS; i++)
			send_word(ssq_pkg::REQ_WRITE, ssq_pkg::IDX_W'(i), ssq_pkg::VAL_W'($urandom));
	endtask

	// Every request code under the reset configuration, including a trigger
	// right after each kind of reset, which only clears the hold.
	task automatic test_request_kinds();
		send_word(ssq_pkg::REQ_PEEK, 8'hff, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, -16'sd1);
		send_word(ssq_pkg::REQ_RESET_START, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_RESET_STEP, 8'd200, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'hff, 16'sh7fff);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_READ, 8'hff, 16'sh0);
		send_word(ssq_pkg::REQ_READ, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_WRITE, 8'hff, -16'sd32768);
		send_word(ssq_pkg::REQ_READ, 8'd63, 16'sh0);
		send_word(REQ_SPARE_LOW, 8'h55, 16'sh5555);
		send_word(REQ_SPARE_HIGH, 8'haa, -16'sh5556);
	endtask

	// Corner settings: a count of zero and the largest count of 127, reversed
	// bounds, bounds beyond the count, a range of one step, the largest step
	// backward and a step size of zero.
	task automatic test_range_corners();
		set_config(0, 5, 9, 3, 1'b0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_RESET_STEP, 8'hff, 16'sh0);
		send_word(ssq_pkg::REQ_READ, 8'd200, 16'sh0);
		set_config(127, 50, 10, 255, 1'b1);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_RESET_STEP, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		set_config(64, 63, 63, 1, 1'b0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_RESET_STEP, 8'd17, 16'sh0);
		set_config(20, 0, 63, 0, 1'b0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
		send_word(ssq_pkg::REQ_TRIGGER, 8'h00, 16'sh0);
	endtask

	// One random request word, weighted toward triggers so the step walks far.
	task automatic send_random_word();
		int                               pick;
		logic [ssq_pkg::IDX_W-1:0]        idx;
		logic signed [ssq_pkg::VAL_W-1:0] val;
		logic [ssq_pkg::REQ_W-1:0]        spare;
		pick  = $urandom_range(99);
		idx   = ssq_pkg::IDX_W'($urandom);
		val   = ssq_pkg::VAL_W'($urandom);
		spare = ssq_pkg::REQ_W'($urandom_range(REQ_SPARE_HIGH, REQ_SPARE_LOW));
		if (pick < 40)
			send_word(ssq_pkg::REQ_TRIGGER, idx, val);
		else if (pick < 48)
			send_word(ssq_pkg::REQ_RESET_START, idx, val);
		else if (pick < 58)
			send_word(ssq_pkg::REQ_RESET_STEP, idx, val);
		else if (pick < 73)
			send_word(ssq_pkg::REQ_WRITE, idx, val);
		else if (pick < 88)
			send_word(ssq_pkg::REQ_READ, idx, val);
		else if (pick < 95)
			send_word(ssq_pkg::REQ_PEEK, idx, val);
		else
			send_word(spare, idx, val);
	endtask

	// A random setting that still lands on the extremes now and then.
	task automatic random_config();
		int count;
		int step;
		case ($urandom_range(7))
			0:       count = 0;
			1:       count = 1;
			2:       count = 64;
			3:       count = $urandom_range(127, 65);
			default: count = $urandom_range(64, 2);
		endcase
		case ($urandom_range(5))
			0:       step = 0;
			1:       step = 255;
			2:       step = $urandom_range(3, 1);
			default: step = $urandom_range(255);
		endcase
		set_config(count, $urandom_range(63), $urandom_range(63), step,
			1'($urandom_range(1)));
	endtask

	// The result side stalls for a long stretch while request words keep
	// coming, so the block fills up and drops ready on the request side.
	task automatic test_backpressure();
		rx_hold_cycles = LONG_HOLD;
		repeat (16)
			send_random_word();
		drain();
	endtask

	// Random settings and words, under one idling pattern.
	task automatic test_random_traffic(input int src_pct, input int sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (8) begin
			random_config();
			repeat (46)
				send_random_word();
		end
	endtask

	// The result sink: drives ready at the falling edge and checks each result
	// word taken at the rising edge against the oldest prediction.
	initial begin : result_sink
		step_result_t want;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				rsp_bus.ready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
				if (pending_results.size() == 0) begin
					$error("result word with no request waiting for it");
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_bus.out_value !== want.value) begin
						$error("out_value: expected %0d, got %0d", want.value,
							rsp_bus.out_value);
						mismatch_count++;
					end
					if (rsp_bus.current_step !== want.step) begin
						$error("current_step: expected %0d, got %0d", want.step,
							rsp_bus.current_step);
						mismatch_count++;
					end
					if (rsp_bus.at_range_start !== want.at_start) begin
						$error("at_range_start: expected %0b, got %0b", want.at_start,
							rsp_bus.at_range_start);
						mismatch_count++;
					end
					if (rsp_bus.at_range_end !== want.at_end) begin
						$error("at_range_end: expected %0b, got %0b", want.at_end,
							rsp_bus.at_range_end);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog: any handshake on any channel restarts the count of quiet cycles.
	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: reset once, then the directed tests under the first idling
	// pattern, then random traffic under each pattern in turn.
	initial begin : main_sequence
		arst_n             = 1'b0;
		req_bus.valid      = 1'b0;
		req_bus.req_type   = ssq_pkg::REQ_PEEK;
		req_bus.step_index = '0;
		req_bus.step_value = '0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.index      = ssq_pkg::CFG_ACTIVE_COUNT;
		cfg_bus.data       = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		src_idle_pct  = 33;
		sink_idle_pct = 67;
		test_preload();
		test_request_kinds();
		test_range_corners();
		test_backpressure();

		test_random_traffic(33, 67);
		test_random_traffic(67, 33);
		test_random_traffic(0, 0);
		drain();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
